// File: rtl/dash_pattern_segmenter_assert.svh
// assertion macros shared by the dash pattern segmenter modules
// depends on nothing; included inside module bodies
`ifndef DASH_PATTERN_SEGMENTER_ASSERT_SVH
`define DASH_PATTERN_SEGMENTER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define DPS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define DPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dps_pkg.sv
// package for the dash pattern segmenter: widths, register indexes, shared types
// depends on nothing
package dps_pkg;
   localparam int MAX_ENTRIES = 6;
   localparam int MAX_OUT = 64;
   localparam int CW = 24;
   localparam int NREGS = 8;
   localparam int CNT_W = $clog2(MAX_OUT + 1);
   localparam int CAP_RAW = MAX_ENTRIES - (MAX_ENTRIES % 2);
   localparam int ENT_CAP = (CAP_RAW > 6) ? 6 : CAP_RAW;

   localparam logic [2:0] REG_START_OFFSET = 3'd7;
   localparam logic [2:0] REG_PATTERN_ENTRIES = 3'd6;

   localparam logic PEN_MOVE = 1'b0;
   localparam logic PEN_LINE = 1'b1;

   typedef struct packed {
      logic signed [CW-1:0] x_begin;
      logic signed [CW-1:0] y_begin;
      logic signed [CW-1:0] x_finish;
      logic signed [CW-1:0] y_finish;
      logic [CW-1:0] seg_length;
      logic path_first;
   } seg_type;

   typedef struct packed {
      logic signed [CW-1:0] out_x;
      logic signed [CW-1:0] out_y;
      logic pen_cmd;
      logic last_of_run;
      logic truncated;
   } pt_type;

   // work handed from the walker to the interpolator
   typedef struct packed {
      logic interp;
      logic signed [CW-1:0] x_begin;
      logic signed [CW-1:0] y_begin;
      logic signed [CW-1:0] x_finish;
      logic signed [CW-1:0] y_finish;
      logic [CW-1:0] seg_length;
      logic [CW-1:0] rest;
      logic pen_cmd;
      logic last_of_run;
      logic truncated;
   } job_type;
endpackage

// File: rtl/dps_walker.sv
// front part: accepts segments, walks the dash pattern and issues point jobs
// depends on dps_pkg and the assertion header
module dps_walker
   import dps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic seg_valid,
   output logic seg_ready,
   input  seg_type seg,
   input  logic [CW-1:0] len_ff [NREGS],
   output logic job_valid,
   input  logic job_ready,
   output job_type job
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_OFS, ST_OFS_WRAP, ST_WALK, ST_ADV, ST_ADV_WRAP
   } st_type;

   st_type st_ff, st_in;
   seg_type seg_ff, seg_in;
   logic [2:0] idx_ff, idx_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW+1:0] rest_ff, rest_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic trunc_ff, trunc_in;
   logic emit_move_ff, emit_move_in;

   logic [2:0] n;
   logic [CW+2:0] total;
   logic [CW-1:0] d, dr;
   logic [2:0] idx_next;

   always_comb begin
      n = len_ff[REG_PATTERN_ENTRIES][2:0] & 3'd6;
      if (n > 3'(ENT_CAP)) n = 3'(ENT_CAP);
      total = '0;
      for (int i = 0; i < 6; i++)
         if (3'(i) < n) total = total + (CW+3)'(len_ff[i]);
      d = len_ff[idx_ff];
      dr = (d > used_ff) ? d - used_ff : '0;
      idx_next = (idx_ff + 3'd1 >= n) ? 3'd0 : idx_ff + 3'd1;
   end

   always_comb begin
      st_in = st_ff;
      seg_in = seg_ff;
      idx_in = idx_ff;
      used_in = used_ff;
      rest_in = rest_ff;
      cnt_in = cnt_ff;
      trunc_in = trunc_ff;
      emit_move_in = emit_move_ff;
      seg_ready = 1'b0;
      job_valid = 1'b0;
      job = '0;
      job.x_begin = seg_ff.x_begin;
      job.y_begin = seg_ff.y_begin;
      job.x_finish = seg_ff.x_finish;
      job.y_finish = seg_ff.y_finish;
      job.seg_length = seg_ff.seg_length;
      case (st_ff)
         ST_IDLE: begin
            seg_ready = 1'b1;
            if (seg_valid && n >= 3'd2) begin
               seg_in = seg;
               cnt_in = '0;
               trunc_in = 1'b0;
               rest_in = {2'b00, seg.seg_length};
               if (idx_ff >= n) idx_in = 3'd0;
               if (seg.path_first) begin
                  idx_in = 3'd0;
                  used_in = '0;
                  emit_move_in = 1'b1;
                  st_in = ST_OFS;
               end else begin
                  emit_move_in = 1'b0;
                  st_in = ST_WALK;
               end
            end
         end
         // walk start offset from entry 0; rest_ff holds the offset remainder in ST_OFS_WRAP
         ST_OFS: begin
            if (!emit_move_in && 1'b0) st_in = ST_OFS;
            st_in = ST_WALK;
            if (len_ff[REG_START_OFFSET] != '0) begin
               if ({2'b00, len_ff[REG_START_OFFSET]} <= {2'b00, dr}) begin
                  used_in = used_ff + len_ff[REG_START_OFFSET];
               end else begin
                  rest_in = {2'b00, len_ff[REG_START_OFFSET] - dr};
                  idx_in = idx_next;
                  used_in = '0;
                  st_in = (total == '0) ? ST_WALK : ST_OFS_WRAP;
                  if (total != '0) begin
                     // subtract total once if the remainder exceeds it; ST_OFS_WRAP walks entries for the rest
                     if ((CW+3)'(len_ff[REG_START_OFFSET] - dr) > total)
                        rest_in = (CW+2)'((CW+3)'(len_ff[REG_START_OFFSET] - dr)
                                  - total);
                  end
               end
            end
            if (st_in == ST_WALK) rest_in = {2'b00, seg_ff.seg_length};
         end
         ST_OFS_WRAP: begin
            if (rest_ff > (CW+2)'(d)) begin
               rest_in = rest_ff - (CW+2)'(d);
               idx_in = idx_next;
            end else begin
               used_in = rest_ff[CW-1:0];
               rest_in = {2'b00, seg_ff.seg_length};
               st_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (emit_move_ff) begin
               job_valid = 1'b1;
               job.interp = 1'b0;
               job.x_finish = seg_ff.x_begin;
               job.y_finish = seg_ff.y_begin;
               job.pen_cmd = PEN_MOVE;
               if (job_ready) begin
                  emit_move_in = 1'b0;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else if (rest_ff > (CW+2)'(dr)) begin
               if (cnt_ff >= CNT_W'(MAX_OUT - 1)) begin
                  trunc_in = 1'b1;
                  rest_in = rest_ff - (CW+2)'(dr);
                  idx_in = idx_next;
                  used_in = '0;
                  if (total == '0) begin
                     st_in = ST_WALK;
                     rest_in = '0;
                  end else begin
                     if ((CW+3)'(rest_ff - (CW+2)'(dr)) > total)
                        rest_in = (CW+2)'((CW+3)'(rest_ff - (CW+2)'(dr))
                                  - total * (((CW+3)'(rest_ff - (CW+2)'(dr)) - 1)
                                  >= total ? 1 : 0));
                     st_in = ST_ADV_WRAP;
                  end
               end else begin
                  job_valid = 1'b1;
                  job.interp = 1'b1;
                  job.rest = CW'(rest_ff - (CW+2)'(dr));
                  job.pen_cmd = idx_ff[0] ? PEN_MOVE : PEN_LINE;
                  if (job_ready) begin
                     rest_in = rest_ff - (CW+2)'(dr);
                     idx_in = idx_next;
                     used_in = '0;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            end else begin
               job_valid = 1'b1;
               job.interp = 1'b0;
               job.pen_cmd = idx_ff[0] ? PEN_MOVE : PEN_LINE;
               job.last_of_run = 1'b1;
               job.truncated = trunc_ff;
               if (job_ready) begin
                  used_in = used_ff + rest_ff[CW-1:0];
                  st_in = ST_IDLE;
               end
            end
         end
         // remaining length may still exceed total after one subtract; keep subtracting
         ST_ADV_WRAP: begin
            if (rest_ff > (CW+2)'(total)) begin
               rest_in = rest_ff - (CW+2)'(total);
            end else if (rest_ff > (CW+2)'(d)) begin
               rest_in = rest_ff - (CW+2)'(d);
               idx_in = idx_next;
            end else begin
               used_in = rest_ff[CW-1:0];
               rest_in = '0;
               st_in = ST_ADV;
            end
         end
         ST_ADV: begin
            job_valid = 1'b1;
            job.interp = 1'b0;
            job.pen_cmd = idx_ff[0] ? PEN_MOVE : PEN_LINE;
            job.last_of_run = 1'b1;
            job.truncated = 1'b1;
            if (job_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         idx_ff <= '0;
         used_ff <= '0;
         cnt_ff <= '0;
         trunc_ff <= 1'b0;
         emit_move_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         idx_ff <= idx_in;
         used_ff <= used_in;
         cnt_ff <= cnt_in;
         trunc_ff <= trunc_in;
         emit_move_ff <= emit_move_in;
      end
      seg_ff <= seg_in;
      rest_ff <= rest_in;
   end

   `include "dash_pattern_segmenter_assert.svh"
   `DPS_ASSERT_IMP(a_cnt_limit, st_ff == ST_WALK, cnt_ff <= CNT_W'(MAX_OUT - 1),
      "point count beyond limit")
   `DPS_ASSERT_IMP(a_ready_idle, seg_ready, st_ff == ST_IDLE, "ready outside idle")
   `DPS_ASSERT_NEXT(a_end_idle, job_valid && job_ready && job.last_of_run,
      st_ff == ST_IDLE, "walker not idle after end point")
endmodule

// File: rtl/dps_interp.sv
// back part: job queue and serial divider interpolating boundary points
// depends on dps_pkg and the assertion header
module dps_interp
   import dps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic job_valid,
   output logic job_ready,
   input  job_type job,
   output logic pt_valid,
   input  logic pt_ready,
   output pt_type pt
);
   localparam int QD = 2;
   localparam int PW = 2 * CW + 1;
   typedef enum logic [2:0] { S_IDLE, S_MULX, S_DIVX, S_DIVY, S_OUT } st_type;

   job_type q_ff [QD];
   logic [1:0] qcnt_ff, qcnt_in;
   logic qrd_ff, qwr_ff;
   st_type st_ff, st_in;
   job_type cur_ff;
   logic [PW-1:0] num_ff, rem_ff, quo_ff, qx_ff;
   logic negx_ff, negy_ff;
   logic [5:0] bit_ff;
   pt_type pt_ff;
   logic pt_valid_ff;
   logic pop, push;
   logic signed [CW:0] dx, dy;
   logic [PW-1:0] rem_sh;

   assign job_ready = qcnt_ff != 2'(QD);
   assign push = job_valid && job_ready;
   assign pop = st_ff == S_IDLE && qcnt_ff != '0 && !pt_valid_ff;
   assign pt_valid = pt_valid_ff;
   assign pt = pt_ff;
   assign dx = (CW+1)'(cur_ff.x_finish) - (CW+1)'(cur_ff.x_begin);
   assign dy = (CW+1)'(cur_ff.y_finish) - (CW+1)'(cur_ff.y_begin);
   assign rem_sh = {rem_ff[PW-2:0], num_ff[PW-1]};

   always_comb begin
      qcnt_in = qcnt_ff + 2'(push) - 2'(pop);
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (pop) st_in = q_ff[qrd_ff].interp ? S_MULX : S_OUT;
         S_MULX: st_in = S_DIVX;
         S_DIVX: if (bit_ff == '0) st_in = S_DIVY;
         S_DIVY: if (bit_ff == '0) st_in = S_OUT;
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         qcnt_ff <= '0;
         qrd_ff <= 1'b0;
         qwr_ff <= 1'b0;
         pt_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         qcnt_ff <= qcnt_in;
         if (push) begin
            q_ff[qwr_ff] <= job;
            qwr_ff <= ~qwr_ff;
         end
         if (pop) begin
            cur_ff <= q_ff[qrd_ff];
            qrd_ff <= ~qrd_ff;
         end
         if (pt_valid_ff && pt_ready) pt_valid_ff <= 1'b0;
         case (st_ff)
            S_MULX: begin
               negx_ff <= dx[CW];
               negy_ff <= dy[CW];
               num_ff <= PW'(dx[CW] ? -dx : dx) * PW'(cur_ff.rest);
               qx_ff <= PW'(dy[CW] ? -dy : dy) * PW'(cur_ff.rest);
               rem_ff <= '0;
               quo_ff <= '0;
               bit_ff <= 6'(PW - 1);
            end
            S_DIVX, S_DIVY: begin
               if (rem_sh >= PW'(cur_ff.seg_length)) begin
                  rem_ff <= rem_sh - PW'(cur_ff.seg_length);
                  quo_ff <= {quo_ff[PW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[PW-2:0], 1'b0};
               end
               num_ff <= {num_ff[PW-2:0], 1'b0};
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  // quotient done: after x, store x point and load y product; after y, store y point
                  if (st_ff == S_DIVX) begin
                     cur_ff.x_begin <= CW'(cur_ff.x_finish - CW'(negx_ff
                        ? -{quo_ff[PW-2:0], rem_sh >= PW'(cur_ff.seg_length)}
                        : {quo_ff[PW-2:0], rem_sh >= PW'(cur_ff.seg_length)}));
                     num_ff <= qx_ff;
                     rem_ff <= '0;
                     quo_ff <= '0;
                     bit_ff <= 6'(PW - 1);
                  end else begin
                     cur_ff.y_begin <= CW'(cur_ff.y_finish - CW'(negy_ff
                        ? -{quo_ff[PW-2:0], rem_sh >= PW'(cur_ff.seg_length)}
                        : {quo_ff[PW-2:0], rem_sh >= PW'(cur_ff.seg_length)}));
                  end
               end
            end
            S_OUT: begin
               pt_valid_ff <= 1'b1;
               pt_ff.out_x <= cur_ff.interp ? cur_ff.x_begin : cur_ff.x_finish;
               pt_ff.out_y <= cur_ff.interp ? cur_ff.y_begin : cur_ff.y_finish;
               pt_ff.pen_cmd <= cur_ff.pen_cmd;
               pt_ff.last_of_run <= cur_ff.last_of_run;
               pt_ff.truncated <= cur_ff.truncated;
            end
            default: ;
         endcase
      end
   end

   `include "dash_pattern_segmenter_assert.svh"
   `DPS_ASSERT_IMP(a_q_bound, 1'b1, qcnt_ff <= 2'(QD), "queue overflow")
   `DPS_ASSERT_NEXT(a_out_hold, pt_valid && !pt_ready, pt_valid && $stable(pt),
      "result dropped under stall")
   `DPS_ASSERT_IMP(a_no_pop_busy, pop, !pt_valid_ff, "pop while result pending")
endmodule

// File: rtl/dash_pattern_segmenter.sv
// top level of the dash pattern segmenter: register file, walker and interpolator
// depends on dps_pkg, dps_walker, dps_interp
//
// req_ carries one polyline segment per transaction; rsp_ returns points,
// rsp_tlast marking the segment end point. csr_ writes the eight pattern
// registers by index (0..5 lengths, 6 entry count, 7 start offset).
// The walker steps one dash or gap boundary per cycle while the job queue
// has room and queues jobs; the interpolator computes each boundary point
// with two 49-step serial divisions, and a plain end or move point skips
// the divisions. One segment is taken at a time: req_tready returns high
// once its end point has been queued. With fewer than two
// entries a segment is consumed with no result. At reset the registers,
// the pattern phase and all queues clear. If rsp_tready is low the current
// point holds on rsp_ and the queue backs up into the walker.
module dash_pattern_segmenter
   import dps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [119:0] req_tdata,  // x_begin, y_begin, x_finish, y_finish, seg_length
   input  logic req_tlast,          // path_first
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [55:0] rsp_tdata,   // out_x, out_y, pen_cmd, pad
   output logic rsp_tlast,          // last_of_run
   output logic rsp_tuser,          // truncated
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [CW-1:0] csr_data
);
   logic [CW-1:0] reg_ff [NREGS];
   seg_type seg;
   logic job_valid, job_ready;
   job_type job;
   pt_type pt;

   assign csr_ready = 1'b1;
   assign seg.x_begin = req_tdata[23:0];
   assign seg.y_begin = req_tdata[47:24];
   assign seg.x_finish = req_tdata[71:48];
   assign seg.y_finish = req_tdata[95:72];
   assign seg.seg_length = req_tdata[119:96];
   assign seg.path_first = req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NREGS; i++) reg_ff[i] <= '0;
      end else if (csr_valid) begin
         if (csr_index == REG_PATTERN_ENTRIES) reg_ff[csr_index] <= {21'd0, csr_data[2:0]};
         else reg_ff[csr_index] <= csr_data;
      end
   end

   dps_walker u_walker (
      .clock(clock), .reset(reset),
      .seg_valid(req_tvalid), .seg_ready(req_tready), .seg(seg),
      .len_ff(reg_ff),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   dps_interp u_interp (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .pt_valid(rsp_tvalid), .pt_ready(rsp_tready), .pt(pt)
   );

   assign rsp_tdata = {7'd0, pt.pen_cmd, pt.out_y, pt.out_x};
   assign rsp_tlast = pt.last_of_run;
   assign rsp_tuser = pt.truncated;
endmodule

// File: dv/tb_dash_pattern_segmenter.sv
// self-checking testbench for dash_pattern_segmenter: directed and random segment streams
// depends on dps_pkg and the rtl top level; predicts points in a local model of the dash walk
module tb_dash_pattern_segmenter;
   import dps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      IDX_DASH0, IDX_GAP0, IDX_DASH1, IDX_GAP1, IDX_DASH2, IDX_GAP2, IDX_COUNT, IDX_OFFSET
   } reg_idx_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [119:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [CW-1:0] csr_data = '0;

   dash_pattern_segmenter u_top (.*);

   always #10 clock = ~clock;

   seg_type seg_queue[$];
   pt_type point_queue[$];
   seg_type cur_seg;
   bit req_taken = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   bit no_idle = 0;
   int errors = 0;

   // shadow registers and dash phase
   longint unsigned pat_reg[NREGS];
   int unsigned ent_idx = 0;
   longint unsigned ent_used = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int unsigned entries_used();
      int unsigned n, cap;
      n = pat_reg[IDX_COUNT] & 6;
      cap = MAX_ENTRIES & ~1;
      if (cap > 6) cap = 6;
      if (n > cap) n = cap;
      return n;
   endfunction

   function automatic int unsigned step_idx(int unsigned i, int unsigned n);
      i++;
      return (i >= n) ? 0 : i;
   endfunction

   function automatic void skip_phase(longint unsigned r, int unsigned n);
      longint unsigned d, dr, total;
      total = 0;
      if (r == 0) return;
      d = pat_reg[ent_idx];
      dr = (d > ent_used) ? d - ent_used : 0;
      if (r <= dr) begin
         ent_used = (ent_used + r) & 24'hFFFFFF;
         return;
      end
      r -= dr;
      ent_idx = step_idx(ent_idx, n);
      ent_used = 0;
      for (int i = 0; i < n; i++) total += pat_reg[i];
      if (total == 0) return;
      if (r > total) r -= ((r - 1) / total) * total;
      while (r > pat_reg[ent_idx]) begin
         r -= pat_reg[ent_idx];
         ent_idx = step_idx(ent_idx, n);
      end
      ent_used = r;
   endfunction

   function automatic void push_point(longint x, longint y, logic pen, logic last, logic trunc);
      pt_type p;
      p.out_x = x[CW-1:0];
      p.out_y = y[CW-1:0];
      p.pen_cmd = pen;
      p.last_of_run = last;
      p.truncated = trunc;
      point_queue.push_back(p);
   endfunction

   function automatic void predict_points(seg_type s);
      int unsigned n;
      longint xb, yb, xf, yf, qx, qy;
      longint unsigned len, rest, d, dr;
      logic trunc, pen;
      int cnt;
      n = entries_used();
      xb = s.x_begin; yb = s.y_begin; xf = s.x_finish; yf = s.y_finish;
      len = s.seg_length;
      rest = len;
      trunc = 0;
      cnt = 0;
      if (n < 2) return;
      if (ent_idx >= n) ent_idx = 0;
      if (s.path_first) begin
         ent_idx = 0;
         ent_used = 0;
         skip_phase(pat_reg[IDX_OFFSET], n);
         push_point(xb, yb, PEN_MOVE, 0, 0);
         cnt++;
      end
      forever begin
         d = pat_reg[ent_idx];
         dr = (d > ent_used) ? d - ent_used : 0;
         if (rest > dr) begin
            if (cnt >= MAX_OUT - 1) begin
               trunc = 1;
               skip_phase(rest, n);
               break;
            end
            pen = ent_idx[0] ? PEN_MOVE : PEN_LINE;
            rest -= dr;
            ent_idx = step_idx(ent_idx, n);
            ent_used = 0;
            if (len != 0) begin
               qx = (xf - xb) * longint'(rest) / longint'(len);
               qy = (yf - yb) * longint'(rest) / longint'(len);
               push_point(xf - qx, yf - qy, pen, 0, 0);
            end else push_point(xf, yf, pen, 0, 0);
            cnt++;
         end else begin
            ent_used = (ent_used + rest) & 24'hFFFFFF;
            break;
         end
      end
      push_point(xf, yf, ent_idx[0] ? PEN_MOVE : PEN_LINE, 1, trunc);
   endfunction

   // request side
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         predict_points(cur_seg);
         req_taken = 1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 0;
            void'(seg_queue.pop_front());
            req_gap = pick_gap();
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid = 0;
         end else if (seg_queue.size() > 0) begin
            cur_seg = seg_queue[0];
            req_tdata = {cur_seg.seg_length, cur_seg.y_finish, cur_seg.x_finish,
                         cur_seg.y_begin, cur_seg.x_begin};
            req_tlast = cur_seg.path_first;
            req_tvalid = 1;
         end else req_tvalid = 0;
      end
   end

   // response side
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready = 0;
         end else begin
            rsp_tready = 1;
            rsp_gap = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      pt_type exp_pt;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (point_queue.size() == 0) begin
            $display("%0t: unexpected point x=%h y=%h pen=%b last=%b trunc=%b", $realtime,
                     rsp_tdata[23:0], rsp_tdata[47:24], rsp_tdata[48], rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            exp_pt = point_queue.pop_front();
            if (rsp_tdata[23:0] !== exp_pt.out_x || rsp_tdata[47:24] !== exp_pt.out_y ||
                rsp_tdata[48] !== exp_pt.pen_cmd || rsp_tlast !== exp_pt.last_of_run ||
                rsp_tuser !== exp_pt.truncated) begin
               $display("%0t: mismatch expected x=%h y=%h pen=%b last=%b trunc=%b",
                        $realtime, exp_pt.out_x, exp_pt.out_y, exp_pt.pen_cmd,
                        exp_pt.last_of_run, exp_pt.truncated);
               $display("%0t:          actual   x=%h y=%h pen=%b last=%b trunc=%b",
                        $realtime, rsp_tdata[23:0], rsp_tdata[47:24], rsp_tdata[48],
                        rsp_tlast, rsp_tuser);
               errors++;
            end
         end
      end
   end

   task automatic write_reg(reg_idx_t idx, logic [CW-1:0] value);
      @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pat_reg[idx] = (idx == IDX_COUNT) ? value & 7 : value;
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic set_pattern(logic [CW-1:0] d0, logic [CW-1:0] g0, logic [CW-1:0] d1,
                              logic [CW-1:0] g1, logic [CW-1:0] d2, logic [CW-1:0] g2,
                              logic [2:0] cnt, logic [CW-1:0] off);
      write_reg(IDX_DASH0, d0);
      write_reg(IDX_GAP0, g0);
      write_reg(IDX_DASH1, d1);
      write_reg(IDX_GAP1, g1);
      write_reg(IDX_DASH2, d2);
      write_reg(IDX_GAP2, g2);
      write_reg(IDX_COUNT, cnt);
      write_reg(IDX_OFFSET, off);
   endtask

   task automatic drain();
      while (seg_queue.size() > 0 || req_tvalid || point_queue.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic add_seg(logic [CW-1:0] xb, logic [CW-1:0] yb, logic [CW-1:0] xf,
                          logic [CW-1:0] yf, logic [CW-1:0] len, logic first);
      seg_type s;
      s.x_begin = xb; s.y_begin = yb; s.x_finish = xf; s.y_finish = yf;
      s.seg_length = len; s.path_first = first;
      seg_queue.push_back(s);
   endtask

   task automatic random_phase(int items);
      longint unsigned sum;
      logic [CW-1:0] len [6];
      logic [CW-1:0] px, py, nx, ny, sl;
      int mode, left;
      logic first;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) begin
         if (mode == 0) len[i] = $urandom;
         else if ($urandom_range(0, 9) == 0) len[i] = 0;
         else len[i] = $urandom_range(1, 600);
      end
      sum = 0;
      for (int i = 0; i < 6; i++) sum += len[i];
      if (sum == 0) sum = 1;
      set_pattern(len[0], len[1], len[2], len[3], len[4], len[5], $urandom_range(0, 7),
                  ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 3000));
      no_idle = ($urandom_range(0, 3) == 0);
      px = $urandom; py = $urandom;
      left = 0;
      for (int k = 0; k < items; k++) begin
         first = 0;
         if (left == 0) begin
            left = $urandom_range(1, 6);
            first = 1;
            px = $urandom; py = $urandom;
         end
         left--;
         if ($urandom_range(0, 9) == 0) first = $urandom_range(0, 1);
         nx = $urandom; ny = $urandom;
         if (mode == 0 || $urandom_range(0, 30) == 0) sl = $urandom;
         else sl = $urandom_range(1, (sum * 2 > 24'hFFFFFF) ? 24'hFFFFFF : sum * 2);
         if (sl == 0) sl = 1;
         add_seg(px, py, nx, ny, sl, first);
         px = nx; py = ny;
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < NREGS; i++) pat_reg[i] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // no pattern set: segments are consumed silently
      add_seg(24'h000100, 24'h000200, 24'h001000, 24'h002000, 24'h000400, 1);
      add_seg(24'h001000, 24'h002000, 24'h003000, 24'h004000, 24'h000100, 0);
      drain();

      // simple pattern, ends exactly on boundaries, extreme coordinates
      set_pattern(24'd256, 24'd256, 24'd0, 24'd0, 24'd0, 24'd0, 3'd2, 24'd0);
      add_seg(24'h000000, 24'h000000, 24'h000100, 24'h000000, 24'd256, 1);
      add_seg(24'h000100, 24'h000000, 24'h000100, 24'h000100, 24'd256, 0);
      add_seg(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'd1200, 1);
      add_seg(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'd1, 0);
      add_seg(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 0);
      drain();

      // offset equal to first dash, odd entry count rounds down
      set_pattern(24'd300, 24'd100, 24'd50, 24'd70, 24'd0, 24'd0, 3'd5, 24'd300);
      add_seg(24'h010000, 24'hFF0000, 24'h020000, 24'hFE0000, 24'd900, 1);
      add_seg(24'h020000, 24'hFE0000, 24'h000000, 24'h000000, 24'd45, 0);
      drain();

      // all-zero pattern with nonzero offset: truncation walk
      set_pattern(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 3'd2, 24'd500);
      add_seg(24'h000000, 24'h000000, 24'h001000, 24'h001000, 24'd1000, 1);
      add_seg(24'h001000, 24'h001000, 24'h002000, 24'h000000, 24'd3, 0);
      drain();

      // tiny pattern, long segment: output limit reached
      set_pattern(24'd1, 24'd2, 24'd1, 24'd1, 24'd3, 24'd1, 3'd6, 24'd5);
      add_seg(24'h123456, 24'h654321, 24'h800000, 24'h7FFFFF, 24'd2000, 1);
      add_seg(24'h800000, 24'h7FFFFF, 24'h000000, 24'h000000, 24'd9, 0);
      drain();

      // maximum lengths, count 7, full-range offset
      set_pattern(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  3'd7, 24'hFFFFFF);
      add_seg(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'hFFFFFF, 1);
      add_seg(24'h800000, 24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 0);
      drain();

      // single entry: below a pair, no result
      set_pattern(24'd100, 24'd100, 24'd0, 24'd0, 24'd0, 24'd0, 3'd1, 24'd0);
      add_seg(24'h000000, 24'h000000, 24'h000100, 24'h000100, 24'd400, 1);
      drain();

      for (int p = 0; p < 9; p++) random_phase(48);

      if (errors == 0 && point_queue.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
